### rtl/core/rppk_pkg.sv
// ----------------------------------------------------------------------------
// rppk_pkg
// Shared types, constants and helpers for the roll/pitch point kinematics.
// ----------------------------------------------------------------------------
package rppk_pkg;

   localparam int COORD_W    = 32;
   localparam int DELTA_W    = 33;
   localparam int TRIG_W     = 34;
   localparam int MUL_LAT    = 3;
   localparam int FIFO_DEPTH = 4;
   localparam int MAX_ITER   = 30;

   // 1/(2*pi) in Q0.32, 2*pi in Q3.29, pi/2 in Q2.30, CORDIC gain in Q2.30
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
   localparam logic [31:0] TWO_PI_Q29     = 32'd3373259426;
   localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
   localparam logic signed [TRIG_W-1:0] CORDIC_K_Q30 = 34'sd652032874;
   localparam logic [63:0] PROD_LIM = 64'h1000_0000_0000_0000;

   typedef enum logic [2:0] {
      REG_FREQUENCY       = 3'd0,
      REG_ROLL_AMPLITUDE  = 3'd1,
      REG_PITCH_AMPLITUDE = 3'd2,
      REG_PHASE_OFFSET    = 3'd3,
      REG_PITCH_BIAS      = 3'd4,
      REG_CENTER_X        = 3'd5,
      REG_CENTER_Y        = 3'd6,
      REG_CENTER_Z        = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [31:0]        frequency;
      logic signed [31:0] roll_amplitude;
      logic signed [31:0] pitch_amplitude;
      logic signed [31:0] phase_offset;
      logic signed [31:0] pitch_bias;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
   } cfg_type;

   typedef struct packed {
      logic               op;
      logic [31:0]        u1;
      logic [31:0]        u2;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dz;
   } item_type;

   function automatic logic [30:0] atan_q30(input int idx);
      case (idx)
         0:  return 31'd843314857;
         1:  return 31'd497837829;
         2:  return 31'd263043837;
         3:  return 31'd133525159;
         4:  return 31'd67021687;
         5:  return 31'd33543516;
         6:  return 31'd16775851;
         7:  return 31'd8388437;
         8:  return 31'd4194283;
         9:  return 31'd2097149;
         10: return 31'd1048576;
         11: return 31'd524288;
         12: return 31'd262144;
         13: return 31'd131072;
         14: return 31'd65536;
         15: return 31'd32768;
         16: return 31'd16384;
         17: return 31'd8192;
         18: return 31'd4096;
         19: return 31'd2048;
         20: return 31'd1024;
         21: return 31'd512;
         22: return 31'd256;
         23: return 31'd128;
         24: return 31'd64;
         25: return 31'd32;
         26: return 31'd16;
         27: return 31'd8;
         28: return 31'd4;
         29: return 31'd2;
         default: return 31'd0;
      endcase
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'h7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         return 32'h8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

### rtl/core/rolling_pitching_point_kinematics_top.sv
// ----------------------------------------------------------------------------
// rolling_pitching_point_kinematics_top
// Roll/pitch rigid-body point kinematics with APB-style register port.
// ----------------------------------------------------------------------------
// One transaction per clock in sustained operation while rsp_tready holds.
// A request is captured in the front-end register, written into the queue,
// then passes a back-end pipeline of 2*N + 16 stages, where
// N = min(TRIG_ITERATIONS, 30): two CORDIC passes in series (N + 2 stages
// each), three three-stage multipliers along the longest path, two
// angle-to-turn stages and the output register.
// A four-entry queue sits between the front and back ends; the back end
// freezes while a result waits on rsp_tready.
module rolling_pitching_point_kinematics_top #(
   parameter int TRIG_ITERATIONS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // [0] op
   input  logic [127:0] req_tdata,   // [31:0] time_req, [63:32] pos_x,
                                     // [95:64] pos_y, [127:96] pos_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // [31:0] out_x, [63:32] out_y, [95:64] out_z
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int ITER = (TRIG_ITERATIONS > rppk_pkg::MAX_ITER)
                         ? rppk_pkg::MAX_ITER : TRIG_ITERATIONS;

   rppk_pkg::cfg_type     cfg_ff;
   rppk_pkg::reg_idx_type idx;
   rppk_pkg::item_type    f_item, b_item;
   logic                  wr_en, push, full, pop, empty;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = rppk_pkg::reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         case (idx)
            rppk_pkg::REG_FREQUENCY:       cfg_ff.frequency       <= csr_pwdata;
            rppk_pkg::REG_ROLL_AMPLITUDE:  cfg_ff.roll_amplitude  <= csr_pwdata;
            rppk_pkg::REG_PITCH_AMPLITUDE: cfg_ff.pitch_amplitude <= csr_pwdata;
            rppk_pkg::REG_PHASE_OFFSET:    cfg_ff.phase_offset    <= csr_pwdata;
            rppk_pkg::REG_PITCH_BIAS:      cfg_ff.pitch_bias      <= csr_pwdata;
            rppk_pkg::REG_CENTER_X:        cfg_ff.center_x        <= csr_pwdata;
            rppk_pkg::REG_CENTER_Y:        cfg_ff.center_y        <= csr_pwdata;
            rppk_pkg::REG_CENTER_Z:        cfg_ff.center_z        <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         rppk_pkg::REG_FREQUENCY:       csr_prdata = cfg_ff.frequency;
         rppk_pkg::REG_ROLL_AMPLITUDE:  csr_prdata = cfg_ff.roll_amplitude;
         rppk_pkg::REG_PITCH_AMPLITUDE: csr_prdata = cfg_ff.pitch_amplitude;
         rppk_pkg::REG_PHASE_OFFSET:    csr_prdata = cfg_ff.phase_offset;
         rppk_pkg::REG_PITCH_BIAS:      csr_prdata = cfg_ff.pitch_bias;
         rppk_pkg::REG_CENTER_X:        csr_prdata = cfg_ff.center_x;
         rppk_pkg::REG_CENTER_Y:        csr_prdata = cfg_ff.center_y;
         rppk_pkg::REG_CENTER_Z:        csr_prdata = cfg_ff.center_z;
         default:                       csr_prdata = '0;
      endcase
   end

   rppk_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .push(push), .item(f_item), .full(full));

   rppk_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .wr_item(f_item), .full(full),
      .pop(pop), .rd_item(b_item), .empty(empty));

   rppk_back #(.ITER(ITER)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_item(b_item), .in_empty(empty), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

endmodule

### rtl/core/rppk_delay.sv
// ----------------------------------------------------------------------------
// rppk_delay
// Stallable shift line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module rppk_delay #(
   parameter int W = 8,
   parameter int D = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] sh_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         sh_ff[0] <= din;
         for (int i = 1; i < D; i++) begin
            sh_ff[i] <= sh_ff[i-1];
         end
      end
   end

   assign dout = sh_ff[D-1];

endmodule

### rtl/core/rppk_mul.sv
// ----------------------------------------------------------------------------
// rppk_mul
// Three-stage signed multiply, shift right with truncation toward zero,
// magnitude clamped to 2^60. Built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module rppk_mul #(
   parameter int SHIFT = 30
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] op_a,
   input  logic signed [63:0] op_b,
   output logic signed [63:0] prod
);

   logic [63:0]  ua, ub;
   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic         neg1_ff, neg2_ff;
   logic [127:0] sum_ff;
   logic [127:0] sh;
   logic [63:0]  mag;
   logic signed [63:0] prod_ff;

   always_comb begin
      ua = op_a[63] ? 64'(-op_a) : op_a;
      ub = op_b[63] ? 64'(-op_b) : op_b;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff  <= 64'(ua[31:0]) * 64'(ub[31:0]);
         p01_ff  <= 64'(ua[31:0]) * 64'(ub[63:32]);
         p10_ff  <= 64'(ua[63:32]) * 64'(ub[31:0]);
         p11_ff  <= 64'(ua[63:32]) * 64'(ub[63:32]);
         neg1_ff <= op_a[63] ^ op_b[63];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff  <= 128'(p00_ff) + (128'(p01_ff) << 32) + (128'(p10_ff) << 32)
                    + (128'(p11_ff) << 64);
         neg2_ff <= neg1_ff;
      end
   end

   always_comb begin
      sh  = sum_ff >> SHIFT;
      mag = ((sh[127:64] != 64'd0) || (sh[63:0] > rppk_pkg::PROD_LIM))
            ? rppk_pkg::PROD_LIM : sh[63:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= neg2_ff ? -$signed(mag) : $signed(mag);
      end
   end

   assign prod = prod_ff;

endmodule

### rtl/core/rppk_trig.sv
// ----------------------------------------------------------------------------
// rppk_trig
// Pipelined CORDIC: Q0.32 turn in, cos and sin out in signed Q2.30.
// One stage for the half-turn fold and angle scale, one per iteration,
// one for the output sign.
// ----------------------------------------------------------------------------
module rppk_trig #(
   parameter int ITER = 24
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic [31:0]                      turn,
   output logic signed [rppk_pkg::TRIG_W-1:0] cos_out,
   output logic signed [rppk_pkg::TRIG_W-1:0] sin_out
);

   localparam int W = rppk_pkg::TRIG_W;

   logic [31:0]        chk, fold, absr, zmag;
   logic               flip;
   logic signed [31:0] sr;
   logic [61:0]        zprod;
   logic signed [W-1:0] z_in;

   logic signed [W-1:0] x_ff [ITER+1];
   logic signed [W-1:0] y_ff [ITER+1];
   logic signed [W-1:0] z_ff [ITER+1];
   logic                neg_ff [ITER+1];
   logic signed [W-1:0] cos_ff, sin_ff;

   // fold into [-quarter, +quarter) turn, then scale turns to Q30 radians
   always_comb begin
      chk   = turn + 32'h4000_0000;
      flip  = chk[31];
      fold  = flip ? turn + 32'h8000_0000 : turn;
      sr    = $signed(fold);
      absr  = sr[31] ? 32'(-sr) : fold;
      zprod = 62'(absr[30:0]) * 62'(rppk_pkg::HALF_PI_Q30);
      zmag  = zprod[61:30];
      z_in  = sr[31] ? -$signed(W'(zmag)) : $signed(W'(zmag));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= rppk_pkg::CORDIC_K_Q30;
         y_ff[0]   <= '0;
         z_ff[0]   <= z_in;
         neg_ff[0] <= flip;
      end
   end

   for (genvar i = 0; i < ITER; i++) begin : g_iter
      localparam logic signed [W-1:0] ANG = $signed({3'b000, rppk_pkg::atan_q30(i)});
      logic signed [W-1:0] xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][W-1]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - ANG;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + ANG;
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= neg_ff[ITER] ? -x_ff[ITER] : x_ff[ITER];
         sin_ff <= neg_ff[ITER] ? -y_ff[ITER] : y_ff[ITER];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

### rtl/core/rppk_fifo.sv
// ----------------------------------------------------------------------------
// rppk_fifo
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module rppk_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rppk_pkg::item_type wr_item,
   output logic               full,
   input  logic               pop,
   output rppk_pkg::item_type rd_item,
   output logic               empty
);

   localparam int DEPTH = rppk_pkg::FIFO_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   rppk_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, rptr_ff;
   logic [PTR_W:0]     cnt_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + PTR_W'(1);
         end
         cnt_ff <= cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end

   assign full    = (cnt_ff == (PTR_W+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_item = mem_ff[rptr_ff];

endmodule

### rtl/core/rppk_front.sv
// ----------------------------------------------------------------------------
// rppk_front
// Accepts request transactions, forms the two phases and the offsets from
// the rotation centre, and hands items to the queue.
// ----------------------------------------------------------------------------
module rppk_front (
   input  logic               clock,
   input  logic               reset,
   input  rppk_pkg::cfg_type  cfg,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               req_tuser,  // op
   input  logic [127:0]       req_tdata,  // time_req, pos_x, pos_y, pos_z
   output logic               push,
   output rppk_pkg::item_type item,
   input  logic               full
);

   logic               vld_ff;
   logic               op_ff;
   logic [31:0]        ft_ff, psi_turn_ff;
   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   logic [63:0]        ft_prod;
   logic signed [62:0] psi_prod;

   assign req_tready = !vld_ff || !full;
   assign push       = vld_ff && !full;

   always_comb begin
      ft_prod  = 64'(cfg.frequency) * 64'(req_tdata[31:0]);
      psi_prod = 63'($signed(cfg.phase_offset))
                 * 63'($signed({1'b0, rppk_pkg::INV_TWO_PI_Q32}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_tready) begin
         vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         op_ff       <= req_tuser;
         ft_ff       <= ft_prod[31:0];
         psi_turn_ff <= psi_prod[59:28];
         dx_ff <= 33'($signed(req_tdata[63:32])) - 33'($signed(cfg.center_x));
         dy_ff <= 33'($signed(req_tdata[95:64])) - 33'($signed(cfg.center_y));
         dz_ff <= 33'($signed(req_tdata[127:96])) - 33'($signed(cfg.center_z));
      end
   end

   always_comb begin
      item.op = op_ff;
      item.u1 = ft_ff;
      item.u2 = ft_ff + psi_turn_ff;
      item.dx = dx_ff;
      item.dy = dy_ff;
      item.dz = dz_ff;
   end

endmodule

### rtl/core/rppk_back.sv
// ----------------------------------------------------------------------------
// rppk_back
// Angle, rotation and velocity pipeline. Every stage advances together and
// freezes while a finished result waits at the output.
// ----------------------------------------------------------------------------
module rppk_back #(
   parameter int ITER = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  rppk_pkg::cfg_type  cfg,
   input  rppk_pkg::item_type in_item,
   input  logic               in_empty,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [95:0]        rsp_tdata  // out_x, out_y, out_z
);

   localparam int M  = rppk_pkg::MUL_LAT;
   localparam int T  = ITER + 2;
   localparam int P  = 2*T + M + 2;
   localparam int L  = P + 2*M + 1;
   localparam int AW = rppk_pkg::TRIG_W;

   logic         en;
   logic [L:1]   vld_ff;
   logic [50:0]  w_ff;
   logic [63:0]  w_prod;

   logic signed [AW-1:0] c1, s1, c2, s2, cp, sp, ct, st;
   logic signed [63:0]   m_phi, m_th, m_s1, m_s2;
   logic signed [AW-1:0] phi_ff, theta_ff;
   logic [31:0]          phi_turn_ff, theta_turn_ff;
   logic signed [64:0]   phi_prod, theta_prod;

   logic [65:0] dxy_a, dxy_b, dxy_c;
   logic [32:0] dz_b;
   logic signed [63:0] ox, oz, oxdy, ozdy, ozdx;
   logic [95:0] vel_ff, vel_d;
   logic        op_d;

   logic signed [63:0] cpst, cpct, spst, spct, dxct, dyst, dzsp, dzcp;
   logic [255:0]       lin_d;
   logic signed [63:0] dxcpst, dycpct, dxspst, dyspct;
   logic signed [63:0] px, py, pz;
   logic [95:0]        out_ff;

   assign en  = !vld_ff[L] || rsp_tready;
   assign pop = en && !in_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[L-1:1], !in_empty};
      end
   end

   // angular rate 2*pi*f as Q.32; user must keep config static while items are in flight, not enforced here
   assign w_prod = 64'(cfg.frequency) * 64'(rppk_pkg::TWO_PI_Q29);
   always_ff @(posedge clock) begin
      w_ff <= w_prod[63:13];
   end

   rppk_trig #(.ITER(ITER)) u_trig_u1 (
      .clock(clock), .en(en), .turn(in_item.u1), .cos_out(c1), .sin_out(s1));
   rppk_trig #(.ITER(ITER)) u_trig_u2 (
      .clock(clock), .en(en), .turn(in_item.u2), .cos_out(c2), .sin_out(s2));

   rppk_mul #(.SHIFT(30)) u_mul_phi (.clock(clock), .en(en),
      .op_a(64'($signed(cfg.roll_amplitude))), .op_b(64'(c1)), .prod(m_phi));
   rppk_mul #(.SHIFT(30)) u_mul_th (.clock(clock), .en(en),
      .op_a(64'($signed(cfg.pitch_amplitude))), .op_b(64'(c2)), .prod(m_th));
   rppk_mul #(.SHIFT(30)) u_mul_s1 (.clock(clock), .en(en),
      .op_a(64'($signed(cfg.roll_amplitude))), .op_b(64'(s1)), .prod(m_s1));
   rppk_mul #(.SHIFT(30)) u_mul_s2 (.clock(clock), .en(en),
      .op_a(64'($signed(cfg.pitch_amplitude))), .op_b(64'(s2)), .prod(m_s2));

   // roll and pitch angles, then radians to turns
   always_ff @(posedge clock) begin
      if (en) begin
         phi_ff   <= AW'(-m_phi);
         theta_ff <= AW'(64'($signed(cfg.pitch_bias)) - m_th);
      end
   end

   always_comb begin
      phi_prod   = 65'(phi_ff) * 65'($signed({1'b0, rppk_pkg::INV_TWO_PI_Q32}));
      theta_prod = 65'(theta_ff) * 65'($signed({1'b0, rppk_pkg::INV_TWO_PI_Q32}));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phi_turn_ff   <= phi_prod[59:28];
         theta_turn_ff <= theta_prod[59:28];
      end
   end

   rppk_trig #(.ITER(ITER)) u_trig_phi (
      .clock(clock), .en(en), .turn(phi_turn_ff), .cos_out(cp), .sin_out(sp));
   rppk_trig #(.ITER(ITER)) u_trig_theta (
      .clock(clock), .en(en), .turn(theta_turn_ff), .cos_out(ct), .sin_out(st));

   // offsets follow the datapath to where each product needs them
   rppk_delay #(.W(66), .D(T + 2*M)) u_dly_dxy_a (.clock(clock), .en(en),
      .din({in_item.dy, in_item.dx}), .dout(dxy_a));
   rppk_delay #(.W(66), .D(P - T - 2*M)) u_dly_dxy_b (.clock(clock), .en(en),
      .din(dxy_a), .dout(dxy_b));
   rppk_delay #(.W(66), .D(M)) u_dly_dxy_c (.clock(clock), .en(en),
      .din(dxy_b), .dout(dxy_c));
   rppk_delay #(.W(33), .D(P)) u_dly_dz (.clock(clock), .en(en),
      .din(in_item.dz), .dout(dz_b));
   rppk_delay #(.W(1), .D(L - 1)) u_dly_op (.clock(clock), .en(en),
      .din(in_item.op), .dout(op_d));

   // boundary velocity
   rppk_mul #(.SHIFT(28)) u_mul_ox (.clock(clock), .en(en),
      .op_a(64'({13'd0, w_ff})), .op_b(m_s1), .prod(ox));
   rppk_mul #(.SHIFT(28)) u_mul_oz (.clock(clock), .en(en),
      .op_a(64'({13'd0, w_ff})), .op_b(m_s2), .prod(oz));
   rppk_mul #(.SHIFT(32)) u_mul_oxdy (.clock(clock), .en(en),
      .op_a(ox), .op_b(64'($signed(dxy_a[65:33]))), .prod(oxdy));
   rppk_mul #(.SHIFT(32)) u_mul_ozdy (.clock(clock), .en(en),
      .op_a(oz), .op_b(64'($signed(dxy_a[65:33]))), .prod(ozdy));
   rppk_mul #(.SHIFT(32)) u_mul_ozdx (.clock(clock), .en(en),
      .op_a(oz), .op_b(64'($signed(dxy_a[32:0]))), .prod(ozdx));

   always_ff @(posedge clock) begin
      if (en) begin
         vel_ff <= {rppk_pkg::sat32(-oxdy), rppk_pkg::sat32(ozdx - oxdy),
                    rppk_pkg::sat32(-ozdy)};
      end
   end

   rppk_delay #(.W(96), .D(T + 1)) u_dly_vel (.clock(clock), .en(en),
      .din(vel_ff), .dout(vel_d));

   // rotation matrix terms
   rppk_mul #(.SHIFT(30)) u_mul_cpst (.clock(clock), .en(en),
      .op_a(64'(cp)), .op_b(64'(st)), .prod(cpst));
   rppk_mul #(.SHIFT(30)) u_mul_cpct (.clock(clock), .en(en),
      .op_a(64'(cp)), .op_b(64'(ct)), .prod(cpct));
   rppk_mul #(.SHIFT(30)) u_mul_spst (.clock(clock), .en(en),
      .op_a(64'(sp)), .op_b(64'(st)), .prod(spst));
   rppk_mul #(.SHIFT(30)) u_mul_spct (.clock(clock), .en(en),
      .op_a(64'(sp)), .op_b(64'(ct)), .prod(spct));
   rppk_mul #(.SHIFT(30)) u_mul_dxct (.clock(clock), .en(en),
      .op_a(64'($signed(dxy_b[32:0]))), .op_b(64'(ct)), .prod(dxct));
   rppk_mul #(.SHIFT(30)) u_mul_dyst (.clock(clock), .en(en),
      .op_a(64'($signed(dxy_b[65:33]))), .op_b(64'(st)), .prod(dyst));
   rppk_mul #(.SHIFT(30)) u_mul_dzsp (.clock(clock), .en(en),
      .op_a(64'($signed(dz_b))), .op_b(64'(sp)), .prod(dzsp));
   rppk_mul #(.SHIFT(30)) u_mul_dzcp (.clock(clock), .en(en),
      .op_a(64'($signed(dz_b))), .op_b(64'(cp)), .prod(dzcp));

   rppk_delay #(.W(256), .D(M)) u_dly_lin (.clock(clock), .en(en),
      .din({dzcp, dzsp, dyst, dxct}), .dout(lin_d));

   rppk_mul #(.SHIFT(30)) u_mul_dxcpst (.clock(clock), .en(en),
      .op_a(64'($signed(dxy_c[32:0]))), .op_b(cpst), .prod(dxcpst));
   rppk_mul #(.SHIFT(30)) u_mul_dycpct (.clock(clock), .en(en),
      .op_a(64'($signed(dxy_c[65:33]))), .op_b(cpct), .prod(dycpct));
   rppk_mul #(.SHIFT(30)) u_mul_dxspst (.clock(clock), .en(en),
      .op_a(64'($signed(dxy_c[32:0]))), .op_b(spst), .prod(dxspst));
   rppk_mul #(.SHIFT(30)) u_mul_dyspct (.clock(clock), .en(en),
      .op_a(64'($signed(dxy_c[65:33]))), .op_b(spct), .prod(dyspct));

   always_comb begin
      px = 64'($signed(cfg.center_x)) + $signed(lin_d[63:0]) - $signed(lin_d[127:64]);
      py = 64'($signed(cfg.center_y)) + dxcpst + dycpct + $signed(lin_d[191:128]);
      pz = 64'($signed(cfg.center_z)) - dxspst - dyspct + $signed(lin_d[255:192]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= op_d ? vel_d
                        : {rppk_pkg::sat32(pz), rppk_pkg::sat32(py), rppk_pkg::sat32(px)};
      end
   end

   assign rsp_tvalid = vld_ff[L];
   assign rsp_tdata  = out_ff;

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline valids moved during a stall");

   a_no_intake_on_stall: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[L] && !rsp_tready) |-> !pop)
      else $error("queue popped while output is stalled");

   a_pop_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      pop |=> vld_ff[1])
      else $error("popped transaction did not enter the pipeline");

endmodule
